// ===== rtl/slab_size_class_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// slab allocator assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_TOP_DEFINES_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SSCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slab allocator assertion failed");
// next-cycle implication
`define SSCA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slab allocator assertion failed");
`else
`define SSCA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSCA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ssca_pkg.sv =====
// ----------------------------------------------------------------------------
// slab allocator package
// constants, codes, command and result types and size helpers
// ----------------------------------------------------------------------------
package ssca_pkg;

   localparam int ADDR_W         = 48;
   localparam int DATA_W         = 64;
   localparam int CLASS_W        = 6;
   localparam int MIN_BLOCK_LOG2 = 4;
   localparam int SLAB_CLASSES   = 8;
   localparam int SLAB_IDX_W     = 3;
   localparam int SLAB_MAX_BYTES = 2048;
   localparam int SLAB_BYTES     = 65536;
   localparam int FREE_DEPTH     = 64;
   localparam int FREE_IDX_W     = 6;
   localparam int FREE_CNT_W     = 7;
   localparam int STACK_ENTRIES  = SLAB_CLASSES * FREE_DEPTH;
   localparam int STACK_IDX_W    = SLAB_IDX_W + FREE_IDX_W;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_FREE_STACK = 3'd1,
      ACT_BUMP       = 3'd2,
      ACT_NEW_SLAB   = 3'd3,
      ACT_LARGE_MAP  = 3'd4,
      ACT_UNCHANGED  = 3'd5,
      ACT_REMAP      = 3'd6,
      ACT_OVERFLOW   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      REL_NONE    = 2'd0,
      REL_PUSHED  = 2'd1,
      REL_DROPPED = 2'd2,
      REL_UNMAP   = 2'd3
   } release_type;

   // classified item handed from front to back, result fields preset
   typedef struct packed {
      action_type              action;
      logic [ADDR_W-1:0]       addr;
      logic [ADDR_W-1:0]       blk;
      logic [ADDR_W-1:0]       base;
      logic [DATA_W-1:0]       map_bytes;
      logic [DATA_W-1:0]       unmap_bytes;
      logic [DATA_W-1:0]       copy_bytes;
      logic [CLASS_W-1:0]      size_class;
      logic                    do_grant;
      logic                    grant_small;
      logic [SLAB_IDX_W-1:0]   grant_cls;
      logic                    do_release;
      logic                    release_small;
      logic [SLAB_IDX_W-1:0]   release_cls;
   } cmd_type;

   typedef struct packed {
      action_type              action;
      release_type             rel;
      logic [ADDR_W-1:0]       addr;
      logic [DATA_W-1:0]       map_bytes;
      logic [DATA_W-1:0]       unmap_bytes;
      logic [DATA_W-1:0]       copy_bytes;
      logic [CLASS_W-1:0]      size_class;
   } res_type;

   // number of significant bits
   function automatic logic [6:0] bit_len(input logic [DATA_W-1:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (v[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

   // power-of-two class of a byte count
   function automatic logic [CLASS_W-1:0] class_of(input logic [DATA_W-1:0] s);
      logic [6:0] bl;
      bl = bit_len(s - 64'd1);
      if (s <= (64'd1 << MIN_BLOCK_LOG2)) return '0;
      return CLASS_W'(bl - 7'(MIN_BLOCK_LOG2));
   endfunction

endpackage

// ===== rtl/slab_size_class_allocator_top.sv =====
// ----------------------------------------------------------------------------
// slab size class allocator
// Requests (allocate, free, resize) enter on the req_ queue port: an item is
// taken when req_push is high and req_full low. Results leave on the rsp_
// queue port: the oldest result shows while rsp_empty is low and is taken
// when rsp_pop is high. csr_wr_en writes page_shift from csr_wr_data.
// The front end takes each item through four steps of a pair of 32x32
// multipliers for the two 64-bit products, one accumulate, one class and
// page rounding step, one classify step that waits while the command
// queue is full, and the idle state that takes the next item. The back end
// runs stack reads and releases, overlapping the front through a two-entry
// command queue. The front end takes no new item before the last is queued.
// Reset empties all stacks and forgets all slabs, and sets page_shift to 12.
// When rsp_pop is held low the result stays put, the back end waits, the
// command queue fills and then req_full stays high.
// ----------------------------------------------------------------------------
module slab_size_class_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [4:0]                    csr_wr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [ssca_pkg::DATA_W-1:0]   req_element_count,
   input  logic [ssca_pkg::DATA_W-1:0]   req_element_size,
   input  logic [ssca_pkg::DATA_W-1:0]   req_old_element_count,
   input  logic [ssca_pkg::DATA_W-1:0]   req_old_element_size,
   input  logic [ssca_pkg::DATA_W-1:0]   req_alignment,
   input  logic [ssca_pkg::ADDR_W-1:0]   req_block_address,
   input  logic [ssca_pkg::ADDR_W-1:0]   req_fresh_base,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_action,
   output logic [1:0]                    rsp_release_res,
   output logic [ssca_pkg::ADDR_W-1:0]   rsp_result_address,
   output logic [ssca_pkg::DATA_W-1:0]   rsp_map_bytes,
   output logic [ssca_pkg::DATA_W-1:0]   rsp_unmap_bytes,
   output logic [ssca_pkg::DATA_W-1:0]   rsp_copy_bytes,
   output logic [ssca_pkg::CLASS_W-1:0]  rsp_size_class
);

   logic [4:0]        page_shift_ff;
   logic              q_push, q_full, q_pop, q_empty;
   ssca_pkg::cmd_type q_in, q_out;
   ssca_pkg::res_type res;
   logic              res_valid;

   // page size register
   always_ff @(posedge clock) begin
      if (reset) page_shift_ff <= 5'd12;
      else if (csr_wr_en) page_shift_ff <= csr_wr_data;
   end

   ssca_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .page_shift            (page_shift_ff),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_operation         (req_operation),
      .req_element_count     (req_element_count),
      .req_element_size      (req_element_size),
      .req_old_element_count (req_old_element_count),
      .req_old_element_size  (req_old_element_size),
      .req_alignment         (req_alignment),
      .req_block_address     (req_block_address),
      .req_fresh_base        (req_fresh_base),
      .q_push                (q_push),
      .q_data                (q_in),
      .q_full                (q_full)
   );

   ssca_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   ssca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .out       (res),
      .out_valid (res_valid)
   );

   // result ports
   assign rsp_empty          = !res_valid;
   assign rsp_action         = res.action;
   assign rsp_release_res    = res.rel;
   assign rsp_result_address = res.addr;
   assign rsp_map_bytes      = res.map_bytes;
   assign rsp_unmap_bytes    = res.unmap_bytes;
   assign rsp_copy_bytes     = res.copy_bytes;
   assign rsp_size_class     = res.size_class;

endmodule

// ===== rtl/ssca_front.sv =====
// ----------------------------------------------------------------------------
// slab allocator front end
// takes items, forms byte totals and classes, queues a classified command
// ----------------------------------------------------------------------------
module ssca_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [4:0]                    page_shift,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [ssca_pkg::DATA_W-1:0]   req_element_count,
   input  logic [ssca_pkg::DATA_W-1:0]   req_element_size,
   input  logic [ssca_pkg::DATA_W-1:0]   req_old_element_count,
   input  logic [ssca_pkg::DATA_W-1:0]   req_old_element_size,
   input  logic [ssca_pkg::DATA_W-1:0]   req_alignment,
   input  logic [ssca_pkg::ADDR_W-1:0]   req_block_address,
   input  logic [ssca_pkg::ADDR_W-1:0]   req_fresh_base,
   output logic                          q_push,
   output ssca_pkg::cmd_type             q_data,
   input  logic                          q_full
);

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_CLS, F_DEC} fstate_type;

   fstate_type                    state_ff, state_in;
   logic [1:0]                    step_ff, step_in;
   logic                          accept;

   ssca_pkg::op_type              op_ff;
   logic [63:0]                   cnt_ff, size_ff, ocnt_ff, osize_ff, align_ff;
   logic [47:0]                   blk_ff, base_ff;
   logic [63:0]                   pp_n_ff, pp_o_ff;
   logic [1:0]                    pp_sh_ff;
   logic [127:0]                  acc_n_ff, acc_o_ff;
   logic [127:0]                  add_n, add_o;
   logic [31:0]                   a_n, b_n, a_o, b_o;

   logic [63:0]                   nt_ff, ot_ff, np_ff, opg_ff;
   logic                          novf_ff, oovf_ff, np_ok_ff, op_ok_ff;
   logic [5:0]                    nc_ff, oc_ff;

   logic [63:0]                   nt_w, ot_w, pm1;
   logic [64:0]                   np_sum, op_sum;
   logic [5:0]                    cls_a, cls_n, cls_o;

   logic                          small_n, small_o, both_large;
   ssca_pkg::cmd_type             cmd;

   assign accept   = (state_ff == F_IDLE) && req_push;
   assign req_full = (state_ff != F_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_push   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            step_in = '0;
            if (req_push) state_in = F_MUL;
         end
         F_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = F_SUM;
         end
         F_SUM: state_in = F_CLS;
         F_CLS: state_in = F_DEC;
         F_DEC: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // partial product operand selection, low and high halves
   assign a_n = step_ff[1] ? cnt_ff[63:32]  : cnt_ff[31:0];
   assign b_n = step_ff[0] ? size_ff[63:32] : size_ff[31:0];
   assign a_o = step_ff[1] ? ocnt_ff[63:32] : ocnt_ff[31:0];
   assign b_o = step_ff[0] ? osize_ff[63:32] : osize_ff[31:0];

   // align previous partial product
   always_comb begin
      case (pp_sh_ff)
         2'd0: begin
            add_n = {64'b0, pp_n_ff};
            add_o = {64'b0, pp_o_ff};
         end
         2'd1: begin
            add_n = {32'b0, pp_n_ff, 32'b0};
            add_o = {32'b0, pp_o_ff, 32'b0};
         end
         default: begin
            add_n = {pp_n_ff, 64'b0};
            add_o = {pp_o_ff, 64'b0};
         end
      endcase
   end

   // classes and page rounding
   assign nt_w   = acc_n_ff[63:0];
   assign ot_w   = acc_o_ff[63:0];
   assign pm1    = (64'd1 << page_shift) - 64'd1;
   assign np_sum = {1'b0, nt_w} + {1'b0, pm1};
   assign op_sum = {1'b0, ot_w} + {1'b0, pm1};
   assign cls_a  = ssca_pkg::class_of(align_ff);
   assign cls_n  = ssca_pkg::class_of(nt_w);
   assign cls_o  = ssca_pkg::class_of(ot_w);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= ssca_pkg::op_type'(req_operation);
         cnt_ff   <= req_element_count;
         size_ff  <= req_element_size;
         ocnt_ff  <= req_old_element_count;
         osize_ff <= req_old_element_size;
         align_ff <= req_alignment;
         blk_ff   <= req_block_address;
         base_ff  <= req_fresh_base;
         acc_n_ff <= '0;
         acc_o_ff <= '0;
      end else if ((state_ff == F_MUL && step_ff != 2'd0) || state_ff == F_SUM) begin
         acc_n_ff <= acc_n_ff + add_n;
         acc_o_ff <= acc_o_ff + add_o;
      end
      if (state_ff == F_MUL) begin
         pp_n_ff  <= a_n * b_n;
         pp_o_ff  <= a_o * b_o;
         pp_sh_ff <= 2'(step_ff[0]) + 2'(step_ff[1]);
      end
      if (state_ff == F_CLS) begin
         nt_ff    <= nt_w;
         ot_ff    <= ot_w;
         novf_ff  <= |acc_n_ff[127:64];
         oovf_ff  <= |acc_o_ff[127:64];
         nc_ff    <= (cls_a > cls_n) ? cls_a : cls_n;
         oc_ff    <= (cls_a > cls_o) ? cls_a : cls_o;
         np_ok_ff <= !np_sum[64];
         op_ok_ff <= !op_sum[64];
         np_ff    <= np_sum[63:0] & ~pm1;
         opg_ff   <= op_sum[63:0] & ~pm1;
      end
   end

   // classify into a command
   always_comb begin
      small_n    = (nt_ff <= 64'(ssca_pkg::SLAB_MAX_BYTES)) &&
                   (nc_ff < 6'(ssca_pkg::SLAB_CLASSES));
      small_o    = (ot_ff <= 64'(ssca_pkg::SLAB_MAX_BYTES)) &&
                   (oc_ff < 6'(ssca_pkg::SLAB_CLASSES));
      both_large = (nt_ff > 64'(ssca_pkg::SLAB_MAX_BYTES)) &&
                   (ot_ff > 64'(ssca_pkg::SLAB_MAX_BYTES));
      cmd        = '0;
      cmd.blk    = blk_ff;
      cmd.base   = base_ff;
      case (op_ff)
         ssca_pkg::OP_ALLOC, ssca_pkg::OP_FREE: begin
            if (novf_ff || (!small_n && !np_ok_ff)) begin
               cmd.action = ssca_pkg::ACT_OVERFLOW;
            end else begin
               cmd.size_class = nc_ff;
               if (op_ff == ssca_pkg::OP_ALLOC) begin
                  cmd.do_grant    = 1'b1;
                  cmd.grant_small = small_n;
                  cmd.grant_cls   = nc_ff[2:0];
                  cmd.map_bytes   = small_n ? 64'd0 : np_ff;
               end else begin
                  cmd.do_release    = 1'b1;
                  cmd.release_small = small_n;
                  cmd.release_cls   = nc_ff[2:0];
                  cmd.unmap_bytes   = small_n ? 64'd0 : np_ff;
               end
            end
         end
         ssca_pkg::OP_RESIZE: begin
            if (novf_ff || oovf_ff) begin
               cmd.action = ssca_pkg::ACT_OVERFLOW;
            end else if (small_n && small_o && nc_ff == oc_ff) begin
               cmd.action     = ssca_pkg::ACT_UNCHANGED;
               cmd.addr       = blk_ff;
               cmd.size_class = nc_ff;
            end else if (both_large) begin
               if (!np_ok_ff || !op_ok_ff) begin
                  cmd.action = ssca_pkg::ACT_OVERFLOW;
               end else begin
                  cmd.size_class = nc_ff;
                  cmd.addr       = blk_ff;
                  if (np_ff == opg_ff) begin
                     cmd.action = ssca_pkg::ACT_UNCHANGED;
                  end else begin
                     cmd.action      = ssca_pkg::ACT_REMAP;
                     cmd.map_bytes   = np_ff;
                     cmd.unmap_bytes = opg_ff;
                  end
               end
            end else if ((!small_n && !np_ok_ff) || (!small_o && !op_ok_ff)) begin
               cmd.action = ssca_pkg::ACT_OVERFLOW;
            end else begin
               // move: grant the new block, then release the old one
               cmd.size_class    = nc_ff;
               cmd.do_grant      = 1'b1;
               cmd.grant_small   = small_n;
               cmd.grant_cls     = nc_ff[2:0];
               cmd.map_bytes     = small_n ? 64'd0 : np_ff;
               cmd.do_release    = 1'b1;
               cmd.release_small = small_o;
               cmd.release_cls   = oc_ff[2:0];
               cmd.unmap_bytes   = small_o ? 64'd0 : opg_ff;
               cmd.copy_bytes    = (ot_ff < nt_ff) ? ot_ff : nt_ff;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign q_data = cmd;

endmodule

// ===== rtl/ssca_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// slab allocator command queue
// two-entry queue between front end and back end
// ----------------------------------------------------------------------------
module ssca_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssca_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output ssca_pkg::cmd_type pop_data,
   output logic              empty
);

   ssca_pkg::cmd_type entry_ff [2];
   logic              wptr_ff, rptr_ff;
   logic [1:0]        count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

// ===== rtl/ssca_back.sv =====
// ----------------------------------------------------------------------------
// slab allocator back end
// runs grants and releases on the per-class stacks and bump regions, and passes large maps and unmaps through
// ----------------------------------------------------------------------------
`include "slab_size_class_allocator_top_defines.svh"

module ssca_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ssca_pkg::cmd_type q_data,
   output logic              q_pop,
   input  logic              rsp_pop,
   output ssca_pkg::res_type out,
   output logic              out_valid
);

   typedef enum logic [2:0] {B_IDLE, B_GRANT, B_RDWAIT, B_RELEASE, B_DONE} bstate_type;

   localparam int AW = ssca_pkg::ADDR_W;

   bstate_type                          state_ff, state_in;
   ssca_pkg::cmd_type                   cmd_ff;
   ssca_pkg::res_type                   res_ff, out_ff;
   logic                                out_valid_ff;
   logic                                out_load, pop_ok;

   logic [ssca_pkg::FREE_CNT_W-1:0]     cnt_ff [ssca_pkg::SLAB_CLASSES];
   logic                                bv_ff  [ssca_pkg::SLAB_CLASSES];
   logic [AW-1:0]                       pos_ff [ssca_pkg::SLAB_CLASSES];
   logic [AW-1:0]                       end_ff [ssca_pkg::SLAB_CLASSES];

   logic [AW-1:0]                       stack_mem [ssca_pkg::STACK_ENTRIES];
   logic [AW-1:0]                       rd_ff;
   logic                                mem_re, mem_we;
   logic [ssca_pkg::STACK_IDX_W-1:0]    raddr, waddr;

   logic [ssca_pkg::SLAB_IDX_W-1:0]     gc, rc;
   logic [ssca_pkg::FREE_CNT_W-1:0]     g_cnt, g_dec, r_cnt;
   logic                                g_hit, g_fit, r_full;
   logic [AW-1:0]                       csize, slab_pos, slab_end;
   logic [AW:0]                         g_sum;

   // per-class lookups
   always_comb begin
      gc       = cmd_ff.grant_cls;
      rc       = cmd_ff.release_cls;
      g_cnt    = cnt_ff[gc];
      g_dec    = g_cnt - 7'd1;
      g_hit    = (g_cnt != '0);
      csize    = AW'(1) << (ssca_pkg::MIN_BLOCK_LOG2 + int'(gc));
      g_sum    = {1'b0, pos_ff[gc]} + {1'b0, csize};
      g_fit    = bv_ff[gc] && (g_sum <= {1'b0, end_ff[gc]});
      slab_pos = cmd_ff.base + csize;
      slab_end = cmd_ff.base + AW'(ssca_pkg::SLAB_BYTES);
      r_cnt    = cnt_ff[rc];
      r_full   = (r_cnt >= ssca_pkg::FREE_CNT_W'(ssca_pkg::FREE_DEPTH));
      mem_re   = (state_ff == B_GRANT) && cmd_ff.grant_small && g_hit;
      mem_we   = (state_ff == B_RELEASE) && cmd_ff.release_small && !r_full;
      raddr    = {gc, g_dec[ssca_pkg::FREE_IDX_W-1:0]};
      waddr    = {rc, r_cnt[ssca_pkg::FREE_IDX_W-1:0]};
   end

   assign pop_ok   = rsp_pop && out_valid_ff;
   assign out_load = (state_ff == B_DONE) && (!out_valid_ff || rsp_pop);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_data.do_grant) state_in = B_GRANT;
               else if (q_data.do_release) state_in = B_RELEASE;
               else state_in = B_DONE;
            end
         end
         B_GRANT: begin
            if (mem_re) state_in = B_RDWAIT;
            else if (cmd_ff.do_release) state_in = B_RELEASE;
            else state_in = B_DONE;
         end
         B_RDWAIT: state_in = cmd_ff.do_release ? B_RELEASE : B_DONE;
         B_RELEASE: state_in = B_DONE;
         B_DONE: begin
            if (out_load) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // control state, stack fill levels and slab flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ssca_pkg::SLAB_CLASSES; i++) begin
            cnt_ff[i] <= '0;
            bv_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (pop_ok) out_valid_ff <= 1'b0;
         if (state_ff == B_GRANT && cmd_ff.grant_small) begin
            if (g_hit) cnt_ff[gc] <= g_dec;
            else if (!g_fit) bv_ff[gc] <= 1'b1;
         end
         if (mem_we) cnt_ff[rc] <= r_cnt + 7'd1;
      end
   end

   // command, result and bump region registers
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            cmd_ff             <= q_data;
            res_ff.action      <= q_data.action;
            res_ff.rel         <= ssca_pkg::REL_NONE;
            res_ff.addr        <= q_data.addr;
            res_ff.map_bytes   <= q_data.map_bytes;
            res_ff.unmap_bytes <= q_data.unmap_bytes;
            res_ff.copy_bytes  <= q_data.copy_bytes;
            res_ff.size_class  <= q_data.size_class;
         end
         B_GRANT: begin
            if (!cmd_ff.grant_small) begin
               res_ff.action <= ssca_pkg::ACT_LARGE_MAP;
               res_ff.addr   <= cmd_ff.base;
            end else if (!g_hit) begin
               if (g_fit) begin
                  res_ff.action <= ssca_pkg::ACT_BUMP;
                  res_ff.addr   <= pos_ff[gc];
                  pos_ff[gc]    <= g_sum[AW-1:0];
               end else begin
                  res_ff.action    <= ssca_pkg::ACT_NEW_SLAB;
                  res_ff.addr      <= cmd_ff.base;
                  res_ff.map_bytes <= 64'(ssca_pkg::SLAB_BYTES);
                  pos_ff[gc]       <= slab_pos;
                  end_ff[gc]       <= slab_end;
               end
            end
         end
         B_RDWAIT: begin
            res_ff.action <= ssca_pkg::ACT_FREE_STACK;
            res_ff.addr   <= rd_ff;
         end
         B_RELEASE: begin
            if (!cmd_ff.release_small) res_ff.rel <= ssca_pkg::REL_UNMAP;
            else if (r_full) res_ff.rel <= ssca_pkg::REL_DROPPED;
            else res_ff.rel <= ssca_pkg::REL_PUSHED;
         end
         default: begin
         end
      endcase
      if (out_load) out_ff <= res_ff;
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[waddr] <= cmd_ff.blk;
      if (mem_re) rd_ff <= stack_mem[raddr];
   end

   assign out       = out_ff;
   assign out_valid = out_valid_ff;

   `SSCA_ASSERT_IMP(a_rdwait_follows_grant, clock, reset, state_ff == B_RDWAIT, $past(state_ff) == B_GRANT)
   `SSCA_ASSERT_NXT(a_load_shows_result, clock, reset, out_load, out_valid_ff)
   `SSCA_ASSERT_IMP(a_take_only_when_idle, clock, reset, q_pop, state_ff == B_IDLE && !q_empty)

endmodule
